// ----- sv/jadz_pkg.sv -----
// ----------------------------------------------------------------------------
// jadz_pkg - shared definitions for the joystick auto-calibration core
// Widths, reset values, register indexes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package jadz_pkg;

	// ADC and derived widths
	localparam int ADC_BITS = 10;
	localparam int CW       = ADC_BITS + 1;      // centred sample, signed
	localparam int CFG_W    = 7;                 // configuration register width
	localparam int POS_W    = 8;                 // position output, signed
	localparam int SPAN_W   = CFG_W + 1;         // range + dead zone
	localparam int QUO_W    = SPAN_W + 1;        // quotient, at most 2*span
	localparam int NUM_W    = ADC_BITS + QUO_W;  // scaled numerator
	localparam int V_W      = QUO_W + 1;         // signed mapped value
	localparam int STEP_W   = $clog2(QUO_W);     // divide step counter

	// Mid-scale and calibration extent reset values
	localparam logic signed [CW-1:0] MID         = CW'(1 << (ADC_BITS - 1));
	localparam logic signed [CW-1:0] LOW_RESET   = CW'(-200);
	localparam logic signed [CW-1:0] HIGH_RESET  = CW'(200);

	// Configuration reset values
	localparam logic [CFG_W-1:0] DEAD_ZONE_RESET    = CFG_W'(64);
	localparam logic [CFG_W-1:0] OUTPUT_RANGE_RESET = CFG_W'(127);

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_DEAD_ZONE    = 1'b0,
		CFG_OUTPUT_RANGE = 1'b1
	} cfg_index_t;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXT  = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_POST = 5'b10000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch input transaction
		logic extend;    // widen calibration extents
		logic multiply;  // form numerator and divisor
		logic step;      // one restoring divide step
		logic emit;      // load output register
	} jadz_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} jadz_stat_t;

endpackage

`default_nettype wire

// ----- sv/jadz_axis.sv -----
// ----------------------------------------------------------------------------
// jadz_axis - one axis of the conditioning datapath
// Centres the sample, tracks calibration extents, scales by a 10x9 multiply
// and a bit-serial restoring divide, then strips the dead zone.
// ----------------------------------------------------------------------------
`default_nettype none

module jadz_axis
	import jadz_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire jadz_cmd_t               cmd,
	input  wire logic [ADC_BITS-1:0]     sample,
	input  wire logic [CFG_W-1:0]        dead_zone,
	input  wire logic [CFG_W-1:0]        output_range,
	output logic signed [POS_W-1:0]      position
);

	logic signed [CW-1:0]     c_q;
	logic signed [CW-1:0]     low_q;
	logic signed [CW-1:0]     high_q;
	logic [ADC_BITS-1:0]      den_q;
	logic [ADC_BITS-1:0]      rem_q;
	logic [QUO_W-1:0]         quo_q;

	logic [SPAN_W-1:0]        span;
	logic [QUO_W-1:0]         twice_span;
	logic signed [CW-1:0]     diff;
	logic signed [CW-1:0]     width;
	logic [NUM_W-1:0]         prod;
	logic [ADC_BITS:0]        rem_sh;
	logic [ADC_BITS:0]        rem_sub;
	logic                     q_bit;
	logic signed [V_W-1:0]    quo_s;
	logic signed [V_W-1:0]    span_s;
	logic signed [V_W-1:0]    dz_s;
	logic signed [V_W-1:0]    v;
	logic signed [V_W-1:0]    pos_w;

	// Scale factor from configuration
	assign span       = SPAN_W'(output_range) + SPAN_W'(dead_zone);
	assign twice_span = {span, 1'b0};

	// Offset into the calibrated window and its width (both non-negative)
	assign diff  = c_q - low_q;
	assign width = high_q - low_q;
	assign prod  = NUM_W'(diff[ADC_BITS-1:0]) * NUM_W'(twice_span);

	// Restoring divide step: quotient bits shift in behind the numerator bits
	assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_bit   = (rem_sh >= {1'b0, den_q});

	// Capture the centred sample
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q <= MID - $signed({1'b0, sample});
		end
	end

	// Widen the calibration extents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cmd.extend) begin
			if (c_q > high_q) begin
				high_q <= c_q;
			end
			if (c_q < low_q) begin
				low_q <= c_q;
			end
		end
	end

	// Load numerator and divisor, then iterate the divider.
	// The quotient never exceeds 2*span, so the upper numerator bits are
	// already below the divisor and start as the partial remainder.
	always_ff @(posedge clk) begin
		if (cmd.multiply) begin
			den_q <= width[ADC_BITS-1:0];
			rem_q <= prod[NUM_W-1:QUO_W];
			quo_q <= prod[QUO_W-1:0];
		end else if (cmd.step) begin
			rem_q <= q_bit ? rem_sub[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
		end
	end

	// Re-centre and remove the dead zone without a step
	assign quo_s  = V_W'(quo_q);
	assign span_s = V_W'(span);
	assign dz_s   = V_W'(dead_zone);
	assign v      = quo_s - span_s;

	always_comb begin
		if (v > dz_s) begin
			pos_w = v - dz_s;
		end else if (v < -dz_s) begin
			pos_w = v + dz_s;
		end else begin
			pos_w = '0;
		end
	end

	assign position = POS_W'(pos_w);

endmodule

`default_nettype wire

// ----- sv/jadz_dp.sv -----
// ----------------------------------------------------------------------------
// jadz_dp - datapath of the joystick auto-calibration core
// Holds configuration, both axis units, the button flags and the output
// register that decouples the result from the next input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jadz_dp
	import jadz_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire jadz_cmd_t               cmd,
	output jadz_stat_t                   stat,
	input  wire logic                    cfg_write,
	input  wire cfg_index_t              cfg_sel,
	input  wire logic [CFG_W-1:0]        cfg_value,
	input  wire logic [ADC_BITS-1:0]     x_sample,
	input  wire logic [ADC_BITS-1:0]     y_sample,
	input  wire logic                    button_a_level,
	input  wire logic                    button_b_level,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [POS_W-1:0]      x_position,
	output logic signed [POS_W-1:0]      y_position,
	output logic                         button_a_pressed,
	output logic                         button_b_pressed
);

	logic [CFG_W-1:0]          dead_zone_q;
	logic [CFG_W-1:0]          output_range_q;
	logic                      btn_a_q;
	logic                      btn_b_q;
	logic                      out_valid_q;
	logic signed [POS_W-1:0]   x_pos_q;
	logic signed [POS_W-1:0]   y_pos_q;
	logic                      btn_a_out_q;
	logic                      btn_b_out_q;
	logic signed [POS_W-1:0]   x_pos_w;
	logic signed [POS_W-1:0]   y_pos_w;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q    <= DEAD_ZONE_RESET;
			output_range_q <= OUTPUT_RANGE_RESET;
		end else if (cfg_write) begin
			case (cfg_sel)
				CFG_DEAD_ZONE:    dead_zone_q    <= cfg_value;
				CFG_OUTPUT_RANGE: output_range_q <= cfg_value;
				default:          ;
			endcase
		end
	end

	// Axis units
	jadz_axis u_axis_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (x_sample),
		.dead_zone    (dead_zone_q),
		.output_range (output_range_q),
		.position     (x_pos_w)
	);

	jadz_axis u_axis_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (y_sample),
		.dead_zone    (dead_zone_q),
		.output_range (output_range_q),
		.position     (y_pos_w)
	);

	// Capture button levels as pressed flags
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			btn_a_q <= ~button_a_level;
			btn_b_q <= ~button_b_level;
		end
	end

	// Output register: load on emit, drop when the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			x_pos_q     <= x_pos_w;
			y_pos_q     <= y_pos_w;
			btn_a_out_q <= btn_a_q;
			btn_b_out_q <= btn_b_q;
		end
	end

	assign stat.out_free    = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign x_position       = x_pos_q;
	assign y_position       = y_pos_q;
	assign button_a_pressed = btn_a_out_q;
	assign button_b_pressed = btn_b_out_q;

endmodule

`default_nettype wire

// ----- sv/jadz_ctrl.sv -----
// ----------------------------------------------------------------------------
// jadz_ctrl - controller of the joystick auto-calibration core
// Sequences capture, extent update, multiply, the divide steps and the
// hand-off of the result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jadz_ctrl
	import jadz_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire jadz_stat_t    stat,
	output jadz_cmd_t          cmd
);

	state_t              state_q;
	state_t              state_nx;
	logic [STEP_W-1:0]   step_q;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nx = S_EXT;
				end
			end
			S_EXT: begin
				cmd.extend = 1'b1;
				state_nx   = S_MUL;
			end
			S_MUL: begin
				cmd.multiply = 1'b1;
				state_nx     = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (step_q == '0) begin
					state_nx = S_POST;
				end
			end
			S_POST: begin
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Divide step counter: load on multiply, count down while dividing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.multiply) begin
			step_q <= STEP_W'(QUO_W - 1);
		end else if (cmd.step && step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/joystick_autocal_deadzone_core.sv -----
// ----------------------------------------------------------------------------
// joystick_autocal_deadzone_core - self-calibrating two-axis stick conditioner
//
// Input channel (in_valid/in_ready) carries one transaction of two ADC samples
// and two active-low button levels. Output channel (out_valid/out_ready)
// returns one transaction per input: signed positions within +/- output_range
// with the dead zone removed, and active-high button flags.
// Configuration channel (cfg_valid/cfg_ready) is always ready; cfg_index
// selects dead_zone (0) or output_range (1). Write it only while idle.
//
// After the input transaction the core runs the extent update, the multiply,
// 9 restoring divide steps and dead-zone removal, in that order. Both axes
// run side by side; the 9-step divider sets the pace, and a new transaction
// is taken only after the previous result has entered the output register.
// If the receiver stalls, the finished result waits in the output register
// while the next input is accepted and processed; that item then holds in
// the final stage until the output register frees up.
// Reset: extents return to -200/+200, dead_zone to 64, output_range to 127,
// and the output channel empties.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_autocal_deadzone_core
	import jadz_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [ADC_BITS-1:0]     x_sample,
	input  wire logic [ADC_BITS-1:0]     y_sample,
	input  wire logic                    button_a_level,
	input  wire logic                    button_b_level,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [POS_W-1:0]      x_position,
	output logic signed [POS_W-1:0]      y_position,
	output logic                         button_a_pressed,
	output logic                         button_b_pressed,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [0:0]              cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	jadz_cmd_t   cmd;
	jadz_stat_t  stat;

	assign cfg_ready = 1'b1;

	jadz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	jadz_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_write        (cfg_valid && cfg_ready),
		.cfg_sel          (cfg_index_t'(cfg_index)),
		.cfg_value        (cfg_data),
		.x_sample         (x_sample),
		.y_sample         (y_sample),
		.button_a_level   (button_a_level),
		.button_b_level   (button_b_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.x_position       (x_position),
		.y_position       (y_position),
		.button_a_pressed (button_a_pressed),
		.button_b_pressed (button_b_pressed)
	);

endmodule

`default_nettype wire

// ----- sv/jadz_checker.sv -----
// ----------------------------------------------------------------------------
// jadz_checker - port-level checks for the joystick auto-calibration core
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module jadz_checker
	import jadz_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_ready,
	input  wire logic                    out_valid,
	input  wire logic                    out_ready,
	input  wire logic signed [POS_W-1:0] x_position,
	input  wire logic signed [POS_W-1:0] y_position
);

	// Block stays busy through the extent and multiply states after taking a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready)
		else $error("input accepted while previous transaction in progress");

	// No result can appear the cycle after accepting into an empty output
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> !out_valid)
		else $error("result emitted before computation finished");

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(x_position) && $stable(y_position))
		else $error("stalled output transaction changed");

	// Positions never reach the negative limit of the field
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_position != -8'sd128) && (y_position != -8'sd128))
		else $error("position outside conditioned range");

endmodule

bind joystick_autocal_deadzone_core jadz_checker u_jadz_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.x_position (x_position),
	.y_position (y_position)
);

`default_nettype wire
